FILE: rtl/core/mgf_pkg.sv
// Shared constants for the morphological gradient filter.
`timescale 1ns / 1ps
`default_nettype none

package mgf_pkg;

  // Default size limits of the block.
  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 4096;

  // Configuration register indexes.
  localparam logic [1:0] REG_ELEMENT_SHAPE = 2'd0;
  localparam logic [1:0] REG_OPERATION     = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd3;

  // Structuring element shapes.
  localparam logic [1:0] SHAPE_PLUS  = 2'd0;
  localparam logic [1:0] SHAPE_VERT  = 2'd1;
  localparam logic [1:0] SHAPE_HORIZ = 2'd2;
  localparam logic [1:0] SHAPE_DIAG  = 2'd3;

  // Result operations.
  localparam logic [1:0] OP_TOP_HAT   = 2'd0;
  localparam logic [1:0] OP_BLACK_HAT = 2'd1;
  localparam logic [1:0] OP_GRADIENT  = 2'd2;

  // Request types.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Register reset values.
  localparam logic [1:0] SHAPE_RESET        = SHAPE_PLUS;
  localparam logic [1:0] OPERATION_RESET    = OP_GRADIENT;
  localparam int         FRAME_WIDTH_RESET  = 1024;
  localparam int         FRAME_HEIGHT_RESET = 1024;

endpackage

`default_nettype wire

FILE: rtl/core/mgf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/morphological_gradient_filter_top.sv
// Streaming 3x3 morphological top-hat, black-hat and gradient filter.
//
// Pixels arrive in raster order on the request channel (in_valid/in_ready),
// one per request with req_type zero. After the last pixel of a frame the
// sender issues drain requests (req_type one) to flush the final row and a
// pixel. Results leave on out_valid/out_ready in raster order, one row plus
// one pixel behind the pixel stream; frame_done marks the last pixel.
// The result of a request that completes a neighborhood passes the RAM read
// stage into the output register. One request is taken every cycle unless
// stalled; each stored pixel or flushing drain reads and writes the line
// buffer RAM once; a RAM word holds both rows above the new pixel side by side.
// When the receiver stalls, the result waits in the output register and one
// more request is held in the RAM read stage; only then is in_ready dropped.
// Configuration writes (cfg_valid/cfg_ready) are taken at any time but are
// meant for an idle block; writing a frame size restarts the frame.
// Reset sets the default element, operation and sizes and clears the frame
// position; the line buffer is not cleared, since stale entries only feed
// taps that lie outside the image.
`timescale 1ns / 1ps
`default_nettype none

module morphological_gradient_filter_top
  import mgf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] result_value,
  output logic              frame_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int LW = $clog2(MAX_WIDTH + 2);

  localparam int W_RESET_INT = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
  localparam int H_RESET_INT = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                               MAX_HEIGHT : FRAME_HEIGHT_RESET;
  localparam logic [WW-1:0] W_RESET = WW'(W_RESET_INT);
  localparam logic [HW-1:0] H_RESET = HW'(H_RESET_INT);

  // Configuration.
  logic [1:0]    shape;
  logic [1:0]    operation;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [WW-1:0] w_clamped;
  logic [HW-1:0] h_clamped;
  logic          cfg_fire;

  // Frame position.
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic [LW-1:0] lag;

  // Request stage.
  logic          accept;
  logic          is_pixel;
  logic          in_done;
  logic          out_open;
  logic          push_a;
  logic          emit_a;
  logic          out_last;
  logic          in_wrap;
  logic          out_wrap;
  logic [WW-1:0] in_col_inc;
  logic [WW-1:0] out_col_inc;
  logic [CW-1:0] rd_col;
  logic          single_row;

  // RAM read stage.
  logic          s1_valid;
  logic          s1_emit;
  logic [CW-1:0] s1_col;
  logic [7:0]    s1_pixel;
  logic          s1_left;
  logic          s1_right;
  logic          s1_up;
  logic          s1_down;
  logic          s1_done;
  logic          s1_fire;
  logic          byp;
  logic [15:0]   byp_data;
  logic [15:0]   ram_q;
  logic [15:0]   rd_word;
  logic [15:0]   wr_data;

  // Window registers.
  logic [7:0] win_top_old;
  logic [7:0] win_top_new;
  logic [7:0] win_mid_old;
  logic [7:0] win_mid_new;
  logic [7:0] win_bot;

  logic [7:0]        tap_val [6];
  logic [5:0]        tap_en;
  logic [7:0]        centre;
  logic [7:0]        lo8;
  logic [7:0]        hi8;
  logic              any_tap;
  logic signed [9:0] lo_s;
  logic signed [9:0] hi_s;
  logic signed [9:0] centre_s;
  logic signed [9:0] result_next;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data[10:0] == 11'd0) begin
      w_clamped = WW'(1);
    end else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(cfg_data[10:0]);
    end
    if (cfg_data[12:0] == 13'd0) begin
      h_clamped = HW'(1);
    end else if (32'(cfg_data[12:0]) > 32'(MAX_HEIGHT)) begin
      h_clamped = HW'(MAX_HEIGHT);
    end else begin
      h_clamped = HW'(cfg_data[12:0]);
    end
  end

  // Request stage decisions.
  assign out_free   = !out_valid || out_ready;
  assign s1_fire    = s1_valid && (!s1_emit || out_free);
  assign in_ready   = !s1_valid || s1_fire;
  assign accept     = in_valid && in_ready;
  assign is_pixel   = req_type == REQ_PIXEL;
  assign in_done    = in_row >= RW'(eff_h);
  assign out_open   = out_row < RW'(eff_h);
  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign in_wrap    = in_col_inc == eff_w;
  assign out_wrap   = out_col_inc == eff_w;
  assign out_last   = out_wrap && (out_row == RW'(eff_h) - RW'(1));
  assign push_a     = is_pixel ? !in_done : (in_done && out_open);
  assign emit_a     = is_pixel ? (!in_done && (lag >= LW'(eff_w) + LW'(1)))
                               : (in_done && out_open);
  assign single_row = eff_h == HW'(1);

  // A one-row frame is only flushed by drains that run one pixel short of
  // the usual lag, so the read looks one column ahead to fetch the right tap.
  assign rd_col = (single_row && !in_wrap) ? CW'(in_col_inc) :
                  (single_row ? '0 : in_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      shape     <= SHAPE_RESET;
      operation <= OPERATION_RESET;
      eff_w     <= W_RESET;
      eff_h     <= H_RESET;
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      lag       <= '0;
    end else begin
      if (accept) begin
        if (push_a) begin
          if (in_wrap) begin
            in_col <= '0;
            in_row <= in_row + RW'(1);
          end else begin
            in_col <= CW'(in_col_inc);
          end
          if (is_pixel && !emit_a) begin
            lag <= lag + LW'(1);
          end
        end
        if (emit_a) begin
          if (out_last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            lag     <= '0;
          end else if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + RW'(1);
          end else begin
            out_col <= CW'(out_col_inc);
          end
        end
      end
      if (cfg_fire) begin
        case (cfg_index)
          REG_ELEMENT_SHAPE: shape <= cfg_data[1:0];
          REG_OPERATION:     operation <= cfg_data[1:0];
          REG_FRAME_WIDTH: begin
            eff_w   <= w_clamped;
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            lag     <= '0;
          end
          REG_FRAME_HEIGHT: begin
            eff_h   <= h_clamped;
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            lag     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Stage registers and the write-to-read bypass of the line buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && push_a;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit  <= emit_a;
      s1_col   <= in_col;
      s1_pixel <= pixel;
      s1_left  <= out_col != '0;
      s1_right <= !out_wrap;
      s1_up    <= out_row != '0;
      s1_down  <= (out_row + RW'(1)) != RW'(eff_h);
      s1_done  <= out_last;
    end
    if (accept && push_a) begin
      byp      <= s1_valid && (rd_col == s1_col);
      byp_data <= wr_data;
    end
  end

  assign rd_word = byp ? byp_data : ram_q;
  // The entry keeps the pixel of this column one row up and the one below it.
  assign wr_data = {rd_word[7:0], s1_pixel};

  mgf_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_col),
    .wdata(wr_data),
    .re   (accept && push_a),
    .raddr(rd_col),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_top_old <= '0;
      win_top_new <= '0;
      win_mid_old <= '0;
      win_mid_new <= '0;
      win_bot     <= '0;
    end else if (s1_fire) begin
      win_top_old <= win_top_new;
      win_top_new <= rd_word[15:8];
      win_mid_old <= win_mid_new;
      win_mid_new <= rd_word[7:0];
      win_bot     <= s1_pixel;
    end
  end

  // Tap order: up, down, left, right, centre, upper-left diagonal.
  always_comb begin
    // A frame of one pixel never fills the middle row; its pixel sits below.
    centre = (single_row && eff_w == WW'(1)) ? win_bot : win_mid_new;
    tap_val[0] = win_top_new;
    tap_val[1] = win_bot;
    tap_val[2] = win_mid_old;
    tap_val[3] = rd_word[7:0];
    tap_val[4] = centre;
    tap_val[5] = win_top_old;
    case (shape)
      SHAPE_PLUS:  tap_en = {1'b0, 1'b1, s1_right, s1_left, s1_down, s1_up};
      SHAPE_VERT:  tap_en = {1'b0, 1'b1, 1'b0, 1'b0, s1_down, s1_up};
      SHAPE_HORIZ: tap_en = {1'b0, 1'b1, s1_right, s1_left, 1'b0, 1'b0};
      default:     tap_en = {s1_left && s1_up, 5'b00000};
    endcase
  end

  always_comb begin
    lo8     = 8'hFF;
    hi8     = 8'h00;
    any_tap = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (tap_en[k]) begin
        any_tap = 1'b1;
        if (tap_val[k] < lo8) begin
          lo8 = tap_val[k];
        end
        if (tap_val[k] > hi8) begin
          hi8 = tap_val[k];
        end
      end
    end
    lo_s     = any_tap ? $signed({2'b00, lo8}) : -10'sd1;
    hi_s     = $signed({2'b00, hi8});
    centre_s = $signed({2'b00, centre});
    case (operation)
      OP_TOP_HAT:   result_next = centre_s - lo_s;
      OP_BLACK_HAT: result_next = hi_s - centre_s;
      default:      result_next = hi_s - lo_s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      result_value <= result_next;
      frame_done   <= s1_done;
    end
  end

endmodule

`default_nettype wire

FILE: sim/morphological_gradient_filter_top_test.sv
// Self-checking testbench for the streaming morphological gradient filter.
`timescale 1ns / 1ps

module morphological_gradient_filter_top_test;
  import mgf_pkg::*;

  localparam int STORE_DEPTH  = 2 * MAX_WIDTH_DEFAULT + 3;
  localparam int MAX_GAP      = 17;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 200;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic signed [9:0] value;
    logic              done;
  } gradient_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              req_type = REQ_PIXEL;
  logic [7:0]        pixel = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic signed [9:0] result_value;
  logic              frame_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_ELEMENT_SHAPE;
  logic [12:0]       cfg_data = 13'd0;

  // Shadow of the block's registers, line history and frame position.
  logic [1:0]  cur_shape;
  logic [1:0]  cur_op;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  line_mem [STORE_DEPTH];
  int          in_col, in_row, out_col, out_row;

  gradient_t predicted_gradients[$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  pixels_stored = 0;
  int  flushing_drains = 0;
  int  frames_completed = 0;
  int  useful_requests = 0;
  int  cycle_count = 0;
  bit  sender_quiet = 1'b0;
  bit  receiver_quiet = 1'b0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen = 1'b0;
  int  ready_wait = 0;
  int  rx_stall;

  morphological_gradient_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .frame_done   (frame_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_gradients.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(bit quiet_side);
    if (quiet_side) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] random_pixel();
    logic [7:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = 8'd0;
      1: v = 8'd255;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int eff_width();
    if (width_reg == 11'd0) return 1;
    if (width_reg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 13'd0) return 1;
    if (height_reg > MAX_HEIGHT_DEFAULT) return MAX_HEIGHT_DEFAULT;
    return int'(height_reg);
  endfunction

  function automatic void clear_positions();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void predictor_reset();
    cur_shape = SHAPE_RESET;
    cur_op = OPERATION_RESET;
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    foreach (line_mem[i]) line_mem[i] = 8'd0;
    clear_positions();
  endfunction

  function automatic void apply_config(logic [1:0] idx, logic [12:0] data);
    case (idx)
      REG_ELEMENT_SHAPE: cur_shape = data[1:0];
      REG_OPERATION: cur_op = data[1:0];
      REG_FRAME_WIDTH: begin
        width_reg = data[10:0];
        clear_positions();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data;
        clear_positions();
      end
      default: ;
    endcase
  endfunction

  function automatic void step_position(inout int col, inout int row, input int w);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
  endfunction

  // Min and max over the element taps that fall inside the frame; with no
  // tap inside, the erosion stays at -1 and the dilation at 0.
  function automatic logic signed [9:0] neighborhood_value(int col, int row, int w, int h);
    int dxs[5];
    int dys[5];
    int taps, x, y, v, lo, hi, centre, res;
    case (cur_shape)
      SHAPE_PLUS: begin
        taps = 5; dxs = '{0, 0, 1, -1, 0}; dys = '{0, -1, 0, 0, 1};
      end
      SHAPE_VERT: begin
        taps = 3; dxs = '{0, 0, 0, 0, 0}; dys = '{0, -1, 1, 0, 0};
      end
      SHAPE_HORIZ: begin
        taps = 3; dxs = '{0, -1, 1, 0, 0}; dys = '{0, 0, 0, 0, 0};
      end
      default: begin
        taps = 1; dxs = '{-1, 0, 0, 0, 0}; dys = '{-1, 0, 0, 0, 0};
      end
    endcase
    lo = -1;
    hi = 0;
    for (int k = 0; k < taps; k++) begin
      x = col + dxs[k];
      y = row + dys[k];
      if (x >= 0 && x < w && y >= 0 && y < h) begin
        v = int'(line_mem[(y * w + x) % STORE_DEPTH]);
        if (lo == -1 || v < lo) lo = v;
        if (v > hi) hi = v;
      end
    end
    centre = int'(line_mem[(row * w + col) % STORE_DEPTH]);
    case (cur_op)
      OP_TOP_HAT: res = centre - lo;
      OP_BLACK_HAT: res = hi - centre;
      default: res = hi - lo;
    endcase
    return res[9:0];
  endfunction

  function automatic void predict_gradient(logic kind, logic [7:0] value);
    int w, h, total, in_pos, out_pos;
    bit emit;
    gradient_t r;
    w = eff_width();
    h = eff_height();
    total = w * h;
    in_pos = in_row * w + in_col;
    out_pos = out_row * w + out_col;
    emit = 1'b0;
    if (kind == REQ_PIXEL) begin
      if (in_pos < total) begin
        line_mem[in_pos % STORE_DEPTH] = value;
        step_position(in_col, in_row, w);
        emit = (in_pos >= out_pos + w + 1);
        pixels_stored++;
        useful_requests++;
      end
    end else begin
      emit = (in_pos >= total) && (out_pos < total);
      if (emit) begin
        flushing_drains++;
        useful_requests++;
      end
    end
    if (emit) begin
      r.value = neighborhood_value(out_col, out_row, w, h);
      r.done = (out_pos + 1 == total);
      predicted_gradients.push_back(r);
      step_position(out_col, out_row, w);
      if (out_pos + 1 >= total) begin
        clear_positions();
        frames_completed++;
      end
    end
  endfunction

  task automatic check_result(input logic signed [9:0] value, input logic done);
    gradient_t want;
    results_checked++;
    if (predicted_gradients.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: result with none pending: expected nothing, actual value %0d done %0b",
                 $time, value, done);
    end else begin
      want = predicted_gradients.pop_front();
      if (value !== want.value) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result_value: expected %0d, actual %0d", $time, want.value, value);
      end
      if (done !== want.done) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: frame_done: expected %0b, actual %0b", $time, want.done, done);
      end
    end
  endtask

  // Result side: checks each result, may stall for a random count after it, and holds off long when hold_toggle flips.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      ready_wait <= 0;
      hold_seen <= hold_toggle;
    end else begin
      if (out_valid && out_ready) check_result(result_value, frame_done);
      if (hold_toggle != hold_seen) begin
        hold_seen <= hold_toggle;
        out_ready <= 1'b0;
        ready_wait <= LONG_HOLD;
      end else if (out_valid && out_ready) begin
        rx_stall = draw_gap(receiver_quiet);
        if (rx_stall > 0) begin
          out_ready <= 1'b0;
          ready_wait <= rx_stall;
        end
      end else if (!out_ready) begin
        if (ready_wait > 1) begin
          ready_wait <= ready_wait - 1;
        end else begin
          out_ready <= 1'b1;
          ready_wait <= 0;
        end
      end
    end
  end

  // Called on a rising edge; returns on the edge where the request is taken.
  task automatic send_item(input logic kind, input logic [7:0] value);
    int gap;
    gap = draw_gap(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pixel <= value;
    do @(posedge clk); while (!in_ready);
    predict_gradient(kind, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_gradients.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_config(idx, data);
    @(posedge clk);
  endtask

  // Unused upper bits of the shape and operation writes carry random data.
  task automatic set_registers(input logic [1:0] shape, input logic [1:0] op,
                               input logic [12:0] wdata, input logic [12:0] hdata);
    logic [12:0] d;
    wait_drained();
    d = $urandom;
    d[1:0] = shape;
    write_reg(REG_ELEMENT_SHAPE, d);
    d = $urandom;
    d[1:0] = op;
    write_reg(REG_OPERATION, d);
    write_reg(REG_FRAME_WIDTH, wdata);
    write_reg(REG_FRAME_HEIGHT, hdata);
  endtask

  // Drains until the result with frame_done has been predicted.
  task automatic finish_frame();
    while (in_row * eff_width() + in_col >= eff_width() * eff_height())
      send_item(REQ_DRAIN, random_pixel());
  endtask

  task automatic test_directed_frame();
    logic [7:0] levels[6];
    levels = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd1};
    // Element and operation stay at their reset values here.
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    foreach (levels[i]) send_item(REQ_PIXEL, levels[i]);
    finish_frame();
  endtask

  task automatic test_special_cases();
    // A zero width (with ignored upper bits set) and zero height give 1x1.
    set_registers(SHAPE_DIAG, OP_RESERVED, 13'h1800, 13'd0);
    send_item(REQ_DRAIN, 8'd77);
    send_item(REQ_PIXEL, 8'd200);
    send_item(REQ_PIXEL, 8'd9);
    send_item(REQ_DRAIN, 8'd0);
    send_item(REQ_DRAIN, 8'd255);
    // The diagonal tap is always outside a 1x1 frame, so these reach the
    // ends of the result range.
    set_registers(SHAPE_DIAG, OP_TOP_HAT, 13'd1, 13'd1);
    send_item(REQ_PIXEL, 8'd255);
    finish_frame();
    set_registers(SHAPE_DIAG, OP_BLACK_HAT, 13'd1, 13'd1);
    send_item(REQ_PIXEL, 8'd255);
    finish_frame();
  endtask

  task automatic test_column_top_hat();
    set_registers(SHAPE_VERT, OP_TOP_HAT, 13'd1, 13'd3);
    send_item(REQ_PIXEL, 8'd10);
    send_item(REQ_PIXEL, 8'd250);
    send_item(REQ_PIXEL, 8'd3);
    finish_frame();
  endtask

  // Large sizes are run as partial frames and then abandoned by a size write.
  task automatic test_size_extremes();
    set_registers(SHAPE_PLUS, OP_BLACK_HAT, 13'h1FFF, 13'd2);
    repeat (1100) send_item(REQ_PIXEL, random_pixel());
    set_registers(SHAPE_VERT, OP_GRADIENT, 13'd1, 13'h1FFF);
    repeat (40) send_item(REQ_PIXEL, random_pixel());
  endtask

  task automatic test_backpressure();
    set_registers(SHAPE_PLUS, OP_GRADIENT, 13'd8, 13'd6);
    sender_quiet = 1'b1;
    hold_toggle <= ~hold_toggle;
    for (int p = 0; p < 48; p++) begin
      if (p == 30) wait_drained();
      send_item(REQ_PIXEL, random_pixel());
    end
    finish_frame();
    sender_quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    int start, total, stop_at;
    bit broken;
    logic [12:0] wd, hd;
    start = useful_requests;
    while (useful_requests - start < RANDOM_ITEMS) begin
      wd = $urandom_range(1, 12);
      if ($urandom_range(0, 11) == 0) wd = 13'd0;
      wd[12:11] = $urandom_range(0, 3);
      hd = $urandom_range(1, 10);
      if ($urandom_range(0, 11) == 0) hd = 13'd0;
      set_registers($urandom_range(0, 3), $urandom_range(0, 3), wd, hd);
      sender_quiet = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      broken = ($urandom_range(0, 9) == 0);
      total = eff_width() * eff_height();
      stop_at = broken ? $urandom_range(0, total - 1) : total;
      for (int p = 0; p < stop_at; p++) begin
        // Early drains are ignored by the block.
        if ($urandom_range(0, 15) == 0) send_item(REQ_DRAIN, random_pixel());
        if ($urandom_range(0, 40) == 0) wait_drained();
        send_item(REQ_PIXEL, random_pixel());
      end
      if (!broken) begin
        // Pixels past the end of the frame input are dropped.
        if ($urandom_range(0, 3) == 0) send_item(REQ_PIXEL, random_pixel());
        finish_frame();
        if ($urandom_range(0, 3) == 0) send_item(REQ_DRAIN, random_pixel());
      end
    end
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    predictor_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frame();
    test_special_cases();
    test_column_top_hat();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    $display("Covered %0d stored pixels, %0d flushing drains, %0d whole frames,",
             pixels_stored, flushing_drains, frames_completed);
    $display("all element shapes and operations; %0d results compared, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
